// ----- src/gcdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_pkg: shared types, constants and calendar helpers
// Request codes, controller/datapath command and status bundles, leap rule,
// divide-by-25 and mod-7 helpers.
// ----------------------------------------------------------------------------
package gcdc_pkg;

	localparam int DefMaxYear = 9999;

	localparam logic [2:0] REQ_LOAD = 3'd0;
	localparam logic [2:0] REQ_NEXT = 3'd1;
	localparam logic [2:0] REQ_PREV = 3'd2;
	localparam logic [2:0] REQ_BACK = 3'd3;
	localparam logic [2:0] REQ_CMP  = 3'd4;

	localparam logic [1:0] ORD_EQUAL   = 2'd0;
	localparam logic [1:0] ORD_LATER   = 2'd1;
	localparam logic [1:0] ORD_EARLIER = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [4:0]  day_in;
		logic [3:0]  month_in;
		logic [13:0] year_in;
		logic [15:0] step_count;
	} req_t;

	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [13:0] year_out;
		logic [8:0]  day_of_year;
		logic [21:0] serial_day;
		logic [2:0]  weekday;
		logic        leap_year;
		logic        input_valid;
		logic [1:0]  order;
		logic [21:0] distance;
		logic        clamped;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch request, start input date checks
		logic eval;      // input serial ready: apply a valid load
		logic step_fwd;  // one day forward
		logic step_bwd;  // one day back
		logic finish;    // build the result from the held date
		logic clamp_set; // mark the result clamped
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] req_type;
		logic       at_min;
		logic       at_max;
		logic       cnt_zero;
	} dp_sts_t;

	// floor(v / 25) by reciprocal multiply, exact for any 14-bit v
	function automatic logic [9:0] div25(input logic [13:0] v);
		logic [26:0] prod;
		prod = 27'(v) * 27'd5243;
		return prod[26:17];
	endfunction

	function automatic logic mult25(input logic [13:0] v);
		return v == (14'(div25(v)) * 14'd25);
	endfunction

	// by 100 = by 4 and (y/4) by 25; by 400 = by 16 and (y/16) by 25
	function automatic logic is_leap(input logic [13:0] y);
		logic by4, by100, by400;
		by4   = (y[1:0] == 2'd0);
		by100 = by4 && mult25({2'd0, y[13:2]});
		by400 = (y[3:0] == 4'd0) && mult25({4'd0, y[13:4]});
		return (by4 && !by100) || by400;
	endfunction

	// 8 == 1 mod 7: fold 3-bit digits
	function automatic logic [2:0] mod7(input logic [21:0] v);
		logic [23:0] w;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [3:0]  s3;
		w  = {2'd0, v};
		s1 = 6'd0;
		for (int i = 0; i < 8; i++)
			s1 = s1 + 6'(w[3*i +: 3]);
		s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
		s3 = 4'(s2[3]) + 4'(s2[2:0]);
		return (s3 == 4'd7) ? 3'd0 : s3[2:0];
	endfunction

	function automatic logic [4:0] last_day(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		r = 5'd31;
		unique case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] r;
		r = 9'd0;
		unique case (m)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/gcdc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_if: valid/ready channel
// Carries one payload of type T with a source and a sink view.
// ----------------------------------------------------------------------------
interface gcdc_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/gregorian_calendar_day_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_calendar_day_counter: proleptic Gregorian date counter
// Holds one date; loads, steps, steps back N days and compares.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Load, compare, next day, previous day
// and unknown codes pass through capture, evaluate, step, settle, format and
// present; the result is held through any output stall. Back-N requests run
// one day per cycle in the shared step unit, until the count is used up or
// the first day 0001-01-01 is reached. The input is ready again the cycle
// after the result transfer. Reset leaves the date at 0001-01-01, serial 1.
module gregorian_calendar_day_counter #(
	parameter int MAX_YEAR = gcdc_pkg::DefMaxYear
) (
	input logic clk,
	input logic arst_n,
	gcdc_if.sink   req,
	gcdc_if.source rsp
);
	gcdc_pkg::dp_cmd_t cmd;
	gcdc_pkg::dp_sts_t sts;

	gcdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	gcdc_datapath #(.MAX_YEAR(MAX_YEAR)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req.data),
		.rsp    (rsp.data)
	);

endmodule

// ----- src/gcdc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_datapath: date registers and arithmetic
// Holds the date and serial, checks input dates, steps days, forms results.
// ----------------------------------------------------------------------------
module gcdc_datapath #(
	parameter int MAX_YEAR = gcdc_pkg::DefMaxYear
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gcdc_pkg::dp_cmd_t  cmd,
	output gcdc_pkg::dp_sts_t  sts,
	input  gcdc_pkg::req_t     req,
	output gcdc_pkg::rsp_t     rsp
);
	localparam logic [13:0] MaxY = 14'(MAX_YEAR);

	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [13:0] year_q;
	logic [21:0] serial_q;
	logic        leap_q;
	logic [2:0]  wd_q;

	logic [2:0]  rtype_q;
	logic [4:0]  din_q;
	logic [3:0]  min_q;
	logic [13:0] yin_q;
	logic [15:0] cnt_q;
	logic        ivalid_q;
	logic        in_leap_q;
	logic [21:0] ybase_q;  // 365*p + p/4 - p/100 + p/400
	logic        clamp_q;

	// input date checks and year base, registered at capture
	logic [13:0] p;
	logic        in_leap, in_valid;
	logic [9:0]  q100;     // p/100 = (p/4)/25, p/400 = (p/100)/4
	logic [21:0] ybase;
	always_comb begin
		p        = req.year_in - 14'd1;
		in_leap  = gcdc_pkg::is_leap(req.year_in);
		in_valid = (req.month_in >= 4'd1) && (req.month_in <= 4'd12)
			&& (req.year_in >= 14'd1) && (req.year_in <= MaxY)
			&& (req.day_in >= 5'd1)
			&& (req.day_in <= gcdc_pkg::last_day(req.month_in, in_leap));
		q100     = gcdc_pkg::div25(p >> 2);
		ybase    = 22'(p * 22'd365) + 22'(p >> 2) - 22'(q100) + 22'(q100 >> 2);
	end

	logic [8:0]  in_doy;
	logic [21:0] in_serial;
	always_comb begin
		in_doy    = gcdc_pkg::days_before(min_q) + 9'(din_q)
			+ 9'((min_q > 4'd2) && in_leap_q);
		in_serial = ybase_q + 22'(in_doy);
	end

	// single-day steps
	logic        cur_leap;
	logic [4:0]  cur_last;
	logic [4:0]  prev_last;
	logic [13:0] ym1;
	always_comb begin
		cur_leap  = gcdc_pkg::is_leap(year_q);
		cur_last  = gcdc_pkg::last_day(month_q, cur_leap);
		ym1       = year_q - 14'd1;
		prev_last = (month_q == 4'd1) ? 5'd31
			: gcdc_pkg::last_day(month_q - 4'd1, cur_leap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q    <= 5'd1;
			month_q  <= 4'd1;
			year_q   <= 14'd1;
			serial_q <= 22'd1;
			clamp_q  <= 1'b0;
		end else begin
			if (cmd.capture)
				clamp_q <= 1'b0;
			if (cmd.clamp_set)
				clamp_q <= 1'b1;
			if (cmd.eval && rtype_q == gcdc_pkg::REQ_LOAD && ivalid_q) begin
				day_q    <= din_q;
				month_q  <= min_q;
				year_q   <= yin_q;
				serial_q <= in_serial;
			end
			if (cmd.step_fwd) begin
				serial_q <= serial_q + 22'd1;
				if (day_q >= cur_last) begin
					day_q <= 5'd1;
					if (month_q >= 4'd12) begin
						month_q <= 4'd1;
						year_q  <= year_q + 14'd1;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end else begin
					day_q <= day_q + 5'd1;
				end
			end
			if (cmd.step_bwd) begin
				serial_q <= serial_q - 22'd1;
				if (day_q > 5'd1) begin
					day_q <= day_q - 5'd1;
				end else if (month_q > 4'd1) begin
					month_q <= month_q - 4'd1;
					day_q   <= prev_last;
				end else begin
					month_q <= 4'd12;
					year_q  <= ym1;
					day_q   <= 5'd31;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rtype_q   <= req.req_type;
			din_q     <= req.day_in;
			min_q     <= req.month_in;
			yin_q     <= req.year_in;
			cnt_q     <= req.step_count;
			ivalid_q  <= in_valid;
			in_leap_q <= in_leap;
			ybase_q   <= ybase;
		end else if (cmd.step_bwd) begin
			cnt_q <= cnt_q - 16'd1;
		end
	end

	// per-date derived values, computed once the date has settled
	always_ff @(posedge clk) begin
		leap_q <= cur_leap;
		wd_q   <= gcdc_pkg::mod7(serial_q);
	end

	logic cmp_ok;
	assign cmp_ok = (rtype_q == gcdc_pkg::REQ_CMP) && ivalid_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp.day_out     <= day_q;
			rsp.month_out   <= month_q;
			rsp.year_out    <= year_q;
			rsp.day_of_year <= gcdc_pkg::days_before(month_q) + 9'(day_q)
				+ 9'((month_q > 4'd2) && leap_q);
			rsp.serial_day  <= serial_q;
			rsp.weekday     <= wd_q;
			rsp.leap_year   <= leap_q;
			rsp.input_valid <= ivalid_q && (rtype_q == gcdc_pkg::REQ_LOAD
				|| rtype_q == gcdc_pkg::REQ_CMP);
			rsp.clamped     <= clamp_q;
			if (cmp_ok && serial_q > in_serial) begin
				rsp.order    <= gcdc_pkg::ORD_LATER;
				rsp.distance <= serial_q - in_serial;
			end else if (cmp_ok && serial_q < in_serial) begin
				rsp.order    <= gcdc_pkg::ORD_EARLIER;
				rsp.distance <= in_serial - serial_q;
			end else begin
				rsp.order    <= gcdc_pkg::ORD_EQUAL;
				rsp.distance <= 22'd0;
			end
		end
	end

	assign sts.req_type = rtype_q;
	assign sts.at_min   = (year_q <= 14'd1) && (month_q == 4'd1) && (day_q == 5'd1);
	assign sts.at_max   = (year_q >= MaxY) && (month_q == 4'd12) && (day_q == 5'd31);
	assign sts.cnt_zero = (cnt_q == 16'd0);

	// serial never drops below 1 and steps never pass the first or the last day
	assert property (@(posedge clk) disable iff (!arst_n) serial_q != 22'd0)
		else $error("serial underflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_bwd |-> !sts.at_min)
		else $error("step back from first day");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_fwd |-> !sts.at_max)
		else $error("step forward past last day");

endmodule

// ----- src/gcdc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdc_ctrl: request sequencer
// Accepts a request, drives the datapath, presents the result.
// ----------------------------------------------------------------------------
module gcdc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output gcdc_pkg::dp_cmd_t  cmd,
	input  gcdc_pkg::dp_sts_t  sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_WORK = 3'd2;
	localparam logic [2:0] S_SETL = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_WORK;
			end
			S_WORK: begin
				state_d = S_SETL;
				unique case (sts.req_type)
					gcdc_pkg::REQ_NEXT: begin
						if (sts.at_max) cmd.clamp_set = 1'b1;
						else cmd.step_fwd = 1'b1;
					end
					gcdc_pkg::REQ_PREV: begin
						if (sts.at_min) cmd.clamp_set = 1'b1;
						else cmd.step_bwd = 1'b1;
					end
					gcdc_pkg::REQ_BACK: begin
						if (!sts.cnt_zero) begin
							state_d = S_WORK;
							if (sts.at_min) begin
								cmd.clamp_set = 1'b1;
								state_d       = S_SETL;
							end else begin
								cmd.step_bwd = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			S_SETL: state_d = S_FIN;
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_EVAL)
		else $error("transfer not followed by evaluation");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.step_fwd, cmd.step_bwd, cmd.eval, cmd.finish}) <= 1)
		else $error("conflicting datapath commands");

endmodule

// ----- dv/gregorian_calendar_day_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_calendar_day_counter_tb: self-checking bench for the date counter
// Drives load, step, back-N, compare and unknown-code requests over the
// request channel, predicts every response with a behavioral calendar and
// compares whole responses, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module gregorian_calendar_day_counter_tb;

	localparam int MaxYear = gcdc_pkg::DefMaxYear;
	localparam logic [2:0] REQ_BAD5 = 3'd5;
	localparam logic [2:0] REQ_BAD7 = 3'd7;

	logic clk;
	logic arst_n;

	gcdc_if #(.T(gcdc_pkg::req_t)) req_ch ();
	gcdc_if #(.T(gcdc_pkg::rsp_t)) rsp_ch ();

	gregorian_calendar_day_counter #(.MAX_YEAR(MaxYear)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// predicted calendar state
	int unsigned cal_day, cal_month, cal_year, cal_serial;

	gcdc_pkg::rsp_t rsp_pending[$];   // responses still to come
	int          n_errors;
	int          n_transfers;
	int          n_checked;
	int          send_idle_pct;    // chance in percent of a gap before a transfer
	int          recv_stall_pct;   // chance in percent of ready low per cycle
	bit          stall_all;        // holds ready low (sender-pause check)

	initial begin
		clk = 1'b0;
	end
	always #1 clk = ~clk;

	function automatic bit leap_of(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		int unsigned tbl[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 2 && leap_of(y)) return 29;
		return tbl[(m - 1) % 12];
	endfunction

	function automatic int unsigned ordinal_of(int unsigned d, int unsigned m, int unsigned y);
		int unsigned cum[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
		int unsigned n;
		n = cum[(m - 1) % 12] + d;
		if (m > 2 && leap_of(y)) n++;
		return n;
	endfunction

	function automatic int unsigned day_number(int unsigned d, int unsigned m, int unsigned y);
		int unsigned p;
		p = y - 1;
		return 365 * p + p / 4 - p / 100 + p / 400 + ordinal_of(d, m, y);
	endfunction

	function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
		if (m < 1 || m > 12) return 0;
		if (y < 1 || y > MaxYear) return 0;
		if (d < 1 || d > month_days(m, y)) return 0;
		return 1;
	endfunction

	function automatic bit advance_day();
		if (cal_year >= MaxYear && cal_month == 12 && cal_day == 31) return 1;
		cal_day++;
		if (cal_day > month_days(cal_month, cal_year)) begin
			cal_day = 1;
			cal_month++;
			if (cal_month > 12) begin
				cal_month = 1;
				cal_year++;
			end
		end
		cal_serial++;
		return 0;
	endfunction

	function automatic bit retreat_day();
		if (cal_year <= 1 && cal_month == 1 && cal_day == 1) return 1;
		if (cal_day > 1) begin
			cal_day--;
		end else begin
			if (cal_month > 1) begin
				cal_month--;
			end else begin
				cal_month = 12;
				cal_year--;
			end
			cal_day = month_days(cal_month, cal_year);
		end
		cal_serial--;
		return 0;
	endfunction

	// applies one request to the predicted calendar, returns the response
	function automatic gcdc_pkg::rsp_t calendar_apply(gcdc_pkg::req_t r);
		gcdc_pkg::rsp_t o;
		int unsigned s, d, m, y;
		o = '0;
		d = 32'(r.day_in);
		m = 32'(r.month_in);
		y = 32'(r.year_in);
		case (r.req_type)
			gcdc_pkg::REQ_LOAD: begin
				if (date_ok(d, m, y)) begin
					o.input_valid = 1'b1;
					cal_day = d;
					cal_month = m;
					cal_year = y;
					cal_serial = day_number(d, m, y);
				end
			end
			gcdc_pkg::REQ_NEXT: o.clamped = advance_day();
			gcdc_pkg::REQ_PREV: o.clamped = retreat_day();
			gcdc_pkg::REQ_BACK: begin
				for (int i = 0; i < int'(r.step_count); i++) begin
					if (retreat_day()) begin
						o.clamped = 1'b1;
						break;
					end
				end
			end
			gcdc_pkg::REQ_CMP: begin
				if (date_ok(d, m, y)) begin
					s = day_number(d, m, y);
					o.input_valid = 1'b1;
					if (cal_serial > s) begin
						o.order = gcdc_pkg::ORD_LATER;
						o.distance = 22'(cal_serial - s);
					end else if (cal_serial < s) begin
						o.order = gcdc_pkg::ORD_EARLIER;
						o.distance = 22'(s - cal_serial);
					end else begin
						o.order = gcdc_pkg::ORD_EQUAL;
					end
				end
			end
			default: ;
		endcase
		o.day_out = 5'(cal_day);
		o.month_out = 4'(cal_month);
		o.year_out = 14'(cal_year);
		o.day_of_year = 9'(ordinal_of(cal_day, cal_month, cal_year));
		o.serial_day = 22'(cal_serial);
		o.weekday = 3'(cal_serial % 7);
		o.leap_year = leap_of(cal_year);
		return o;
	endfunction

	// one transfer on the request channel; prediction made at acceptance
	task automatic send_req(gcdc_pkg::req_t r);
		if (send_idle_pct > 0) begin
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data  = r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		rsp_pending.push_back(calendar_apply(r));
		n_transfers++;
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	function automatic gcdc_pkg::req_t mk_req(logic [2:0] t, int unsigned d, int unsigned m,
			int unsigned y, int unsigned n);
		gcdc_pkg::req_t r;
		r.req_type = t;
		r.day_in = 5'(d);
		r.month_in = 4'(m);
		r.year_in = 14'(y);
		r.step_count = 16'(n);
		return r;
	endfunction

	// mostly valid dates, some junk covering the whole field ranges
	function automatic gcdc_pkg::req_t rand_date_req(logic [2:0] t);
		int unsigned m, y;
		m = $urandom_range(1, 12);
		y = ($urandom_range(3) == 0) ? $urandom_range(1, MaxYear) : $urandom_range(1, 2500);
		if ($urandom_range(7) == 0)
			return mk_req(t, $urandom_range(31), $urandom_range(15), $urandom_range(16383),
				$urandom_range(65535));
		return mk_req(t, $urandom_range(1, month_days(m, y)), m, y, $urandom_range(65535));
	endfunction

	function automatic gcdc_pkg::req_t rand_req();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 20) return rand_date_req(gcdc_pkg::REQ_LOAD);
		if (k < 40) return rand_date_req(gcdc_pkg::REQ_CMP);
		if (k < 62) return mk_req(gcdc_pkg::REQ_NEXT, $urandom_range(31), $urandom_range(15),
			$urandom_range(16383), $urandom_range(65535));
		if (k < 84) return mk_req(gcdc_pkg::REQ_PREV, $urandom_range(31), $urandom_range(15),
			$urandom_range(16383), $urandom_range(65535));
		if (k < 96) return mk_req(gcdc_pkg::REQ_BACK, $urandom_range(31), $urandom_range(15),
			$urandom_range(16383), ($urandom_range(20) == 0) ? $urandom_range(65535)
			: $urandom_range(40));
		return mk_req(3'($urandom_range(REQ_BAD5, REQ_BAD7)), $urandom_range(31),
			$urandom_range(15), $urandom_range(16383), $urandom_range(65535));
	endfunction

	task automatic drain();
		while (rsp_pending.size() != 0) @(negedge clk);
	endtask

	// response checker and ready driver
	always @(negedge clk) begin
		rsp_ch.ready <= !stall_all && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		gcdc_pkg::rsp_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_pending.size() == 0) begin
				$display("%0t: unexpected response %p", $time, rsp_ch.data);
				n_errors++;
			end else begin
				e = rsp_pending.pop_front();
				n_checked++;
				if (e !== rsp_ch.data) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, rsp_ch.data);
					n_errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_req(mk_req(gcdc_pkg::REQ_CMP, 1, 1, 1, 0));      // reset date equals 0001-01-01
		send_req(mk_req(gcdc_pkg::REQ_PREV, 0, 0, 0, 0));     // clamp at the low end
		send_req(mk_req(gcdc_pkg::REQ_BACK, 31, 15, 16383, 65535)); // clamp on back-N
		send_req(mk_req(gcdc_pkg::REQ_BACK, 0, 0, 0, 0));     // zero count
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 31, 12, MaxYear, 0));
		send_req(mk_req(gcdc_pkg::REQ_NEXT, 0, 0, 0, 0));     // clamp at the high end
		send_req(mk_req(gcdc_pkg::REQ_CMP, 1, 1, 1, 0));      // largest distance
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 29, 2, 2000, 0)); // leap by 400
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 29, 2, 1900, 0)); // not leap by 100, rejected
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 29, 2, 2024, 0));
		send_req(mk_req(gcdc_pkg::REQ_NEXT, 0, 0, 0, 0));
		send_req(mk_req(gcdc_pkg::REQ_PREV, 0, 0, 0, 0));
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 1, 13, 2000, 0)); // bad month
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 1, 0, 2000, 0));
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 1, 1, 0, 0));     // bad year
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 1, 1, 10000, 0));
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 0, 1, 2000, 0));  // bad day
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 31, 4, 2000, 0));
		send_req(mk_req(gcdc_pkg::REQ_LOAD, 1, 1, 2001, 0));
		send_req(mk_req(gcdc_pkg::REQ_PREV, 0, 0, 0, 0));     // year wrap back
		send_req(mk_req(gcdc_pkg::REQ_NEXT, 0, 0, 0, 0));     // year wrap forward
		send_req(mk_req(gcdc_pkg::REQ_CMP, 31, 15, 16383, 0)); // invalid compare
		send_req(mk_req(gcdc_pkg::REQ_CMP, 1, 1, 2001, 0));
		send_req(mk_req(gcdc_pkg::REQ_CMP, 2, 1, 2001, 0));
		send_req(mk_req(REQ_BAD7, 31, 15, 16383, 65535));
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) send_req(rand_req());
		drain();
	endtask

	// sender holds off until the output queue is empty
	task automatic test_sender_pause();
		stall_all = 1'b1;
		send_req(mk_req(gcdc_pkg::REQ_NEXT, 0, 0, 0, 0));
		repeat (20) @(negedge clk);
		stall_all = 1'b0;
		drain();
		send_req(mk_req(gcdc_pkg::REQ_PREV, 0, 0, 0, 0));
		drain();
	endtask

	initial begin
		int guard;
		n_errors = 0;
		n_transfers = 0;
		n_checked = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_all = 1'b0;
		cal_day = 1;
		cal_month = 1;
		cal_year = 1;
		cal_serial = 1;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		drain();
		test_sender_pause();
		test_random(500, 0, 0);
		test_random(480, 72, 0);
		test_random(480, 0, 72);
		test_random(480, 36, 36);

		guard = 0;
		while (rsp_pending.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (100) @(negedge clk);
		if (rsp_pending.size() != 0) n_errors++;
		$display("Sent %0d requests, checked %0d responses over four handshake patterns",
			n_transfers, n_checked);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
